// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the ray triangle intersector.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on the following clock edge outside reset.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rti_pkg.sv =====
// Shared widths, register indexes and types of the ray triangle intersector.
// Depends on nothing; used by rti_div and ray_triangle_intersect.
package rti_pkg;

    localparam int CW     = 32;            // coordinate width
    localparam int FB     = 16;            // fraction bits
    localparam int MDW    = 16;            // minimum distance register width
    localparam int CFG_IW = 3;             // configuration index width
    localparam int EW     = CW + 1;        // edge and offset vectors
    localparam int PW     = CW + EW + 1;   // dir x e2
    localparam int QW     = 2 * EW + 1;    // s x e1
    localparam int XW     = EW;            // left dot operand
    localparam int YW     = QW;            // right dot operand
    localparam int LB     = EW;            // low split of the right operand
    localparam int HW     = YW - LB;       // high split of the right operand
    localparam int PPW    = XW + HW;       // partial product width
    localparam int DW     = EW + QW + 2;   // dot product width
    localparam int QB     = CW - 1;        // quotient bits
    localparam int NW     = DW + FB;       // scaled numerator width
    localparam int RW     = DW + QB;       // divider remainder width
    localparam int SW     = DW + QB - FB;  // saturation compare width
    localparam int DISTW  = CW - 1;
    localparam int BW     = FB + 1;
    localparam int ONE_Q  = 1 << FB;
    localparam int FRONT  = 8;             // stages ahead of the divider
    localparam int LAT    = FRONT + QB + 1;
    localparam int TDW_IN  = 9 * CW;
    localparam int TDW_OUT = ((DISTW + 2 * BW + 7) / 8) * 8;

    typedef enum logic [CFG_IW-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MIN_DIST = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic miss;
        logic sat;
    } t_flags;

endpackage

// ===== hdl/ray_triangle_intersect.sv =====
// Top level of the Moller-Trumbore ray triangle intersector.
// Depends on rti_pkg, rti_div and assert_macros.svh.
//
// Usage:
//   The ray (origin, direction, minimum distance) is written through the
//   configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   while no triangle is in flight. o_cfg_ready is always high; indexes past
//   the minimum distance register are ignored.
//   Triangles enter on the slave stream, one transaction per triangle; every
//   triangle yields exactly one result transaction on the master stream.
//   The pipeline holds 8 arithmetic stages (edges, cross products, split
//   dot product partials, sums, sign fix, range tests) followed by a 31-stage
//   restoring divider and an output register. The divider sets the depth.
//   Throughput is one triangle per cycle while the receiver does not stall.
//   Reset returns the ray to origin zero, direction +z, minimum distance 6,
//   and empties the pipeline.
//   When the receiver holds i_m_tready low with a result pending, the whole
//   pipeline freezes and o_s_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CW-1:0]       i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the low bits up
    input  logic [TDW_IN-1:0]   i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // distance, bary_u, bary_v from the low bits up, zero padded
    output logic [TDW_OUT-1:0]  o_m_tdata,
    // hit
    output logic                o_m_tuser
);

    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic [MDW-1:0]       r_min_dist;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en        = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
            end
            r_dir[0]   <= '0;
            r_dir[1]   <= '0;
            r_dir[2]   <= CW'(ONE_Q);
            r_min_dist <= MDW'(6);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                REG_MIN_DIST: r_min_dist <= i_cfg_data[MDW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Stage 1: edges and origin offset.
    logic signed [EW-1:0] r_e1 [3], r_e2 [3], r_s [3];
    logic signed [EW-1:0] r2_e1 [3], r2_e2 [3], r2_s [3];
    logic signed [EW-1:0] r3_e1 [3], r3_e2 [3], r3_s [3];

    for (genvar i = 0; i < 3; i++) begin : g_edge
        logic signed [CW-1:0] w_a, w_b, w_c;
        assign w_a = i_s_tdata[i*CW +: CW];
        assign w_b = i_s_tdata[(3+i)*CW +: CW];
        assign w_c = i_s_tdata[(6+i)*CW +: CW];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_e1[i]  <= EW'(w_b) - EW'(w_a);
                r_e2[i]  <= EW'(w_c) - EW'(w_a);
                r_s[i]   <= EW'(r_org[i]) - EW'(w_a);
                r2_e1[i] <= r_e1[i];
                r2_e2[i] <= r_e2[i];
                r2_s[i]  <= r_s[i];
                r3_e1[i] <= r2_e1[i];
                r3_e2[i] <= r2_e2[i];
                r3_s[i]  <= r2_s[i];
            end
        end
    end

    // Stages 2 and 3: cross products p = dir x e2 and q = s x e1.
    logic signed [CW+EW-1:0] r_pa [3], r_pb [3];
    logic signed [2*EW-1:0]  r_qa [3], r_qb [3];
    logic signed [PW-1:0]    r_p [3];
    logic signed [QW-1:0]    r_q [3];

    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int J1 = (i + 1) % 3;
        localparam int J2 = (i + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa[i] <= r_dir[J1] * r_e2[J2];
                r_pb[i] <= r_dir[J2] * r_e2[J1];
                r_qa[i] <= r_s[J1] * r_e1[J2];
                r_qb[i] <= r_s[J2] * r_e1[J1];
                r_p[i]  <= PW'(r_pa[i]) - PW'(r_pb[i]);
                r_q[i]  <= QW'(r_qa[i]) - QW'(r_qb[i]);
            end
        end
    end

    // Stages 4 to 6: the four dot products det, Nu, Nv, Nt. The right operand
    // is split in two halves so that each multiplier stays near 33 x 34.
    logic signed [PPW-1:0] r_plo [4][3], r_phi [4][3];
    logic signed [DW-1:0]  r_term [4][3];
    logic signed [DW-1:0]  r_dot [4];

    for (genvar d = 0; d < 4; d++) begin : g_dot
        for (genvar i = 0; i < 3; i++) begin : g_term
            logic signed [XW-1:0] w_x;
            logic signed [YW-1:0] w_y;
            always_comb begin
                case (d)
                    0: begin w_x = r3_e1[i];       w_y = YW'(r_p[i]); end
                    1: begin w_x = r3_s[i];        w_y = YW'(r_p[i]); end
                    2: begin w_x = XW'(r_dir[i]);  w_y = r_q[i];      end
                    default: begin w_x = r3_e2[i]; w_y = r_q[i];      end
                endcase
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_plo[d][i]  <= w_x * $signed({1'b0, w_y[LB-1:0]});
                    r_phi[d][i]  <= w_x * $signed(w_y[YW-1:LB]);
                    r_term[d][i] <= (DW'(r_phi[d][i]) <<< LB) + DW'(r_plo[d][i]);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dot[d] <= r_term[d][0] + r_term[d][1] + r_term[d][2];
            end
        end
    end

    // Stage 7: make det positive by negating all four dot products with it; flag a zero det.
    logic signed [DW-1:0] r7_dot [4];
    logic                 r7_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_zero <= (r_dot[0] == '0);
            for (int d = 0; d < 4; d++) begin
                r7_dot[d] <= r_dot[0][DW-1] ? -r_dot[d] : r_dot[d];
            end
        end
    end

    // Stage 8: exact range tests on the rationals, divider operands.
    logic signed [DW:0]   w_uv_sum;
    logic [SW-1:0]        w_sat_rhs;
    t_flags               w_fl;
    t_flags               r8_fl;
    logic [NW-1:0]        r8_nt, r8_nu, r8_nv;
    logic [DW-1:0]        r8_det;

    always_comb begin
        w_uv_sum  = (DW+1)'(r7_dot[1]) + (DW+1)'(r7_dot[2]);
        w_sat_rhs = SW'(r7_dot[0]) << (QB - FB);
        w_fl.miss = r7_zero || r7_dot[1][DW-1] || (r7_dot[1] > r7_dot[0])
                 || r7_dot[2][DW-1] || (w_uv_sum > (DW+1)'(r7_dot[0]))
                 || r7_dot[3][DW-1] || (r7_dot[3] == '0);
        // Quotient at or above 2^QB saturates the distance.
        w_fl.sat  = (SW'(r7_dot[3]) >= w_sat_rhs);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_fl  <= w_fl;
            r8_nt  <= {r7_dot[3], {FB{1'b0}}};
            r8_nu  <= {r7_dot[1], {FB{1'b0}}};
            r8_nv  <= {r7_dot[2], {FB{1'b0}}};
            r8_det <= r7_dot[0];
        end
    end

    logic [QB-1:0] w_qt, w_qu, w_qv;

    rti_div u_div_t (.i_clk(i_clk), .i_en(w_en), .i_num(r8_nt), .i_den(r8_det), .o_quo(w_qt));
    rti_div u_div_u (.i_clk(i_clk), .i_en(w_en), .i_num(r8_nu), .i_den(r8_det), .o_quo(w_qu));
    rti_div u_div_v (.i_clk(i_clk), .i_en(w_en), .i_num(r8_nv), .i_den(r8_det), .o_quo(w_qv));

    // Flags ride alongside the divider.
    t_flags r_fl [QB];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0] <= r8_fl;
            for (int k = 1; k < QB; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    // Output stage: saturation, minimum distance test, zeroing on a miss.
    logic [DISTW-1:0] w_t;
    logic             w_hit;
    logic             r_o_hit;
    logic [DISTW-1:0] r_o_dist;
    logic [BW-1:0]    r_o_u, r_o_v;

    assign w_t   = r_fl[QB-1].sat ? {DISTW{1'b1}} : w_qt[DISTW-1:0];
    assign w_hit = !r_fl[QB-1].miss && (w_t > DISTW'(r_min_dist));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_hit  <= w_hit;
            r_o_dist <= w_hit ? w_t : '0;
            r_o_u    <= w_hit ? w_qu[BW-1:0] : '0;
            r_o_v    <= w_hit ? w_qv[BW-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tuser  = r_o_hit;
    assign o_m_tdata  = TDW_OUT'({r_o_v, r_o_u, r_o_dist});

    `RTI_ASSERT(a_miss_zero, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0, "miss with nonzero fields")
    `RTI_ASSERT(a_hit_far, o_m_tvalid && o_m_tuser |-> r_o_dist > DISTW'(r_min_dist), "hit too close")
    `RTI_ASSERT(a_bary_sum, o_m_tvalid && o_m_tuser |-> (BW+1)'(r_o_u) + (BW+1)'(r_o_v) <= (BW+1)'(ONE_Q), "u plus v above one")
    `RTI_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, $stable(r_vld), "pipeline moved during stall")

endmodule

// ===== hdl/rti_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, QB stages.
// Depends on rti_pkg for the operand and quotient widths.
module rti_div
    import rti_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [RW-1:0] r_rem [QB-1];
    logic [DW-1:0] r_den [QB-1];
    logic [QB-1:0] r_quo [QB];

    // The caller guarantees the quotient fits in QB bits for the cases it uses.
    for (genvar k = 0; k < QB; k++) begin : g_stg
        logic [RW-1:0] w_rin;
        logic [RW-1:0] w_sh;
        logic [DW-1:0] w_din;
        logic [QB-1:0] w_qin;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rin = RW'(i_num);
            assign w_din = i_den;
            assign w_qin = '0;
        end else begin : g_rest
            assign w_rin = r_rem[k-1];
            assign w_din = r_den[k-1];
            assign w_qin = r_quo[k-1];
        end

        assign w_sh = RW'(w_din) << (QB - 1 - k);
        assign w_ge = (w_rin >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {w_qin[QB-2:0], w_ge};
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? (w_rin - w_sh) : w_rin;
                    r_den[k] <= w_din;
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

// ===== sim/ray_triangle_checker.sv =====
// Checker for the ray triangle intersector: watches the configuration and both streams.
// Predicts every result exactly and compares it in order. Depends on rti_pkg.
`timescale 1ns / 100ps

module ray_triangle_checker
    import rti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CW-1:0]       i_cfg_data,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [TDW_IN-1:0]   i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [TDW_OUT-1:0]  i_m_tdata,
    input  logic                i_m_tuser,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int XL = 160;   // wide enough for every exact product and dot

    typedef struct packed {
        logic             hit;
        logic [DISTW-1:0] distance;
        logic [BW-1:0]    u;
        logic [BW-1:0]    v;
    } t_isect;

    logic signed [CW-1:0] ray_org [3];
    logic signed [CW-1:0] ray_dir [3];
    logic [MDW-1:0]       min_dist;
    t_isect               isect_q [$];

    function automatic t_isect predict(input logic [TDW_IN-1:0] vtx);
        logic signed [XL-1:0] e1 [3];
        logic signed [XL-1:0] e2 [3];
        logic signed [XL-1:0] s [3];
        logic signed [XL-1:0] d [3];
        logic signed [XL-1:0] p [3];
        logic signed [XL-1:0] q [3];
        logic signed [XL-1:0] det, nu, nv, nt, tq, uq, vq;
        logic [DISTW-1:0]     t;
        t_isect               r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            e1[k] = $signed(vtx[CW*(3+k) +: CW]) - $signed(vtx[CW*k +: CW]);
            e2[k] = $signed(vtx[CW*(6+k) +: CW]) - $signed(vtx[CW*k +: CW]);
            s[k]  = ray_org[k] - $signed(vtx[CW*k +: CW]);
            d[k]  = ray_dir[k];
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        nv  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det == 0)
            return r;
        if (det < 0) begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt <= 0)
            return r;
        tq = (nt <<< FB) / det;
        if (tq > (2 ** DISTW) - 1)
            t = '1;
        else
            t = tq[DISTW-1:0];
        if (t <= min_dist)
            return r;
        uq = (nu <<< FB) / det;
        vq = (nv <<< FB) / det;
        r.hit      = 1'b1;
        r.distance = t;
        r.u        = uq[BW-1:0];
        r.v        = vq[BW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_isect want, got;
        if (!i_rst_n) begin
            foreach (ray_org[k]) begin
                ray_org[k] = '0;
                ray_dir[k] = '0;
            end
            ray_dir[2] = ONE_Q;
            min_dist   = MDW'(6);
            isect_q.delete();
            o_errors   = 0;
            o_pending  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ORIGIN_X: ray_org[0] = i_cfg_data;
                    REG_ORIGIN_Y: ray_org[1] = i_cfg_data;
                    REG_ORIGIN_Z: ray_org[2] = i_cfg_data;
                    REG_DIR_X:    ray_dir[0] = i_cfg_data;
                    REG_DIR_Y:    ray_dir[1] = i_cfg_data;
                    REG_DIR_Z:    ray_dir[2] = i_cfg_data;
                    REG_MIN_DIST: min_dist   = i_cfg_data[MDW-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                isect_q = {isect_q, predict(i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                got.hit      = i_m_tuser;
                got.distance = i_m_tdata[0 +: DISTW];
                got.u        = i_m_tdata[DISTW +: BW];
                got.v        = i_m_tdata[DISTW+BW +: BW];
                if (isect_q.size() == 0) begin
                    report_mismatch("unexpected result", '0,
                                    64'({got.hit, got.distance}));
                end else begin
                    want = isect_q.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", 64'(want.hit), 64'(got.hit));
                    if (got.distance != want.distance)
                        report_mismatch("distance", 64'(want.distance), 64'(got.distance));
                    if (got.u != want.u)
                        report_mismatch("bary_u", 64'(want.u), 64'(got.u));
                    if (got.v != want.v)
                        report_mismatch("bary_v", 64'(want.v), 64'(got.v));
                end
            end
            o_pending = isect_q.size();
        end
    end

endmodule

// ===== sim/tb_ray_triangle_intersect.sv =====
// Testbench top for the ray triangle intersector: clock, reset, stimulus and verdict.
// Depends on rti_pkg, ray_triangle_intersect and ray_triangle_checker.
`timescale 1ns / 100ps

module tb_ray_triangle_intersect
    import rti_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int ONE = ONE_Q;

    typedef logic [8:0][CW-1:0] t_tri;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index = '0;
    logic [CW-1:0]      i_cfg_data = '0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDW_IN-1:0]  i_s_tdata = '0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDW_OUT-1:0] o_m_tdata;
    logic               o_m_tuser;
    int                 errors;
    int                 pending;
    int                 cycles = 0;

    // Ray as last written, used only to aim triangles at it.
    logic signed [CW-1:0] aim_org [3];
    logic signed [CW-1:0] aim_dir [3];

    ray_triangle_intersect dut (.*);

    ray_triangle_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver backpressure: modes of free flow, light and heavy stalls, and long holds.
    int stall_mode = 0;
    int mode_left = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(10, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= (mode_left % 40 == 0);
        endcase
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx <= REG_ORIGIN_Z)
            aim_org[idx] = value;
        else if (idx <= REG_DIR_Z)
            aim_dir[idx - REG_DIR_X] = value;
    endtask

    task automatic set_ray(input logic [CW-1:0] ox, oy, oz, dx, dy, dz,
                           input logic [MDW-1:0] mind);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_MIN_DIST, {16'($urandom), mind});
    endtask

    task automatic send_tri(input t_tri vtx);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= vtx;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_results();
        pause_sender(0);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_tri xyz3(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri r;
        r = {cz, cy, cx, bz, by, bx, az, ay, ax};
        return r;
    endfunction

    // A triangle scattered around a point on the ray, so a good share of them are hit.
    function automatic t_tri aimed_tri();
        t_tri r;
        logic signed [CW-1:0] pt;
        int span, tk;
        tk   = $urandom_range(0, 40);
        span = 1 << $urandom_range(2, 20);
        for (int k = 0; k < 3; k++) begin
            pt = aim_org[k] + aim_dir[k] * tk;
            r[k]   = pt - $signed($urandom_range(0, span));
            r[3+k] = pt + $signed($urandom_range(0, 2 * span)) - span;
            r[6+k] = pt + $signed($urandom_range(0, 2 * span)) - span;
        end
        if ($urandom_range(0, 1))
            r = {r[5:3], r[8:6], r[2:0]};
        return r;
    endfunction

    function automatic t_tri random_tri();
        t_tri r;
        int kind;
        kind = $urandom_range(0, 19);
        for (int k = 0; k < 9; k++)
            r[k] = $urandom;
        if (kind < 14) begin
            r = aimed_tri();
        end else if (kind < 16) begin
            r[5:3] = r[2:0];                          // two equal vertices
        end else if (kind == 16) begin
            for (int k = 0; k < 3; k++)               // collinear vertices
                r[6+k] = 2 * r[3+k] - r[k];
        end else if (kind == 17) begin
            r = aimed_tri();
            for (int k = 0; k < 9; k += 3)            // all vertices take the ray origin's x
                r[k] = aim_org[0];
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0) begin
                send_tri(random_tri());
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(0, 12));
        end
    endtask

    initial begin
        aim_org = '{0, 0, 0};
        aim_dir = '{0, 0, ONE};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default ray along +z from the origin.
        send_tri(xyz3(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, -ONE, ONE, 2*ONE));
        send_tri(xyz3(ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, -ONE, ONE, 2*ONE));
        send_tri(xyz3(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_tri(xyz3(ONE, -ONE, 0, ONE, ONE, 0, ONE, 0, ONE));
        send_tri(xyz3(ONE, ONE, ONE, 3*ONE, ONE, ONE, ONE, 3*ONE, ONE));
        send_tri(xyz3(-ONE, -ONE, -2*ONE, ONE, -ONE, -2*ONE, -ONE, ONE, -2*ONE));
        send_tri(xyz3(-ONE, -ONE, 5, ONE, -ONE, 5, -ONE, ONE, 5));
        send_tri(xyz3(-ONE, -ONE, 7, ONE, -ONE, 7, -ONE, ONE, 7));
        send_tri(xyz3(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_tri(xyz3(-ONE, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_tri(xyz3(-ONE, -ONE, 32'h7fff0000, ONE, -ONE, 32'h7fff0000,
                      -ONE, ONE, 32'h7fff0000));
        send_tri({9{32'h80000000}});
        send_tri({9{32'h7fffffff}});
        send_tri({3{32'h7fffffff, 32'h80000000, 32'h7fffffff}});
        send_tri(xyz3(32'h80000000, 32'h80000000, ONE, 32'h7fffffff, 32'h80000000, ONE,
                      32'h80000000, 32'h7fffffff, ONE));
        drain_results();

        // Tiny direction: far hits saturate the distance.
        set_ray(0, 0, 0, 0, 0, 1, 0);
        send_tri(xyz3(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, -ONE, ONE, 2*ONE));
        send_tri(xyz3(-ONE, -ONE, 1, ONE, -ONE, 1, -ONE, ONE, 1));
        run_random(150);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_ray(0, 0, 0, 0, 0, ONE, 16'hffff);
                1: set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff, 32'h80000000, 0);
                2: set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff);
                default: set_ray($signed($urandom_range(0, 1 << 21)) - (1 << 20),
                                 $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                                 $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                                 $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                                 $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                                 $signed($urandom_range(0, 1 << 19)) - (1 << 18),
                                 MDW'($urandom_range(0, 3) == 0 ? $urandom
                                                                : $urandom_range(0, 9)));
            endcase
            // An index past the register list must leave the ray alone.
            if (ph == 3) begin
                @(negedge i_clk);
                i_cfg_valid <= 1'b1;
                i_cfg_index <= '1;
                i_cfg_data  <= $urandom;
                do @(posedge i_clk); while (!o_cfg_ready);
                @(negedge i_clk);
                i_cfg_valid <= 1'b0;
            end
            run_random(ph < 3 ? 90 : 200);
            drain_results();
        end

        repeat (LAT + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
